// File: design/pol_pkg.sv
// Package with the shared types, codes and defaults of the positional ordered list.
package pol_pkg;

   // Default sizes handed to the top level parameters.
   localparam int DEF_CAPACITY    = 64;
   localparam int DEF_VALUE_WIDTH = 32;

   // Fixed field widths of the request and response channels.
   localparam int REQ_TYPE_W   = 3;
   localparam int ITEM_W       = 32;
   localparam int POSITION_W   = 7;
   localparam int STATUS_W     = 3;

   // Request operation codes.
   typedef enum logic [REQ_TYPE_W-1:0] {
      OP_INS_FRONT = 3'd0,
      OP_INS_BACK  = 3'd1,
      OP_INS_POS   = 3'd2,
      OP_DEL_FRONT = 3'd3,
      OP_DEL_BACK  = 3'd4,
      OP_DEL_POS   = 3'd5,
      OP_SEARCH    = 3'd6
   } op_type;

   // Response status codes.
   typedef enum logic [STATUS_W-1:0] {
      ST_OK       = 3'd0,
      ST_BADPOS   = 3'd1,
      ST_EMPTY    = 3'd2,
      ST_FULL     = 3'd3,
      ST_NOTFOUND = 3'd4
   } status_type;

   // What every element cell does with its stored value.
   typedef enum logic [1:0] {
      SH_HOLD,
      SH_INSERT,
      SH_DELETE
   } shift_type;

   // What every element cell does with its probe register.
   typedef enum logic [1:0] {
      PR_HOLD,
      PR_LOAD_DEL,
      PR_LOAD_SEARCH,
      PR_FOLD
   } probe_type;

   // Broadcast control from the controller to the row of cells.
   typedef struct packed {
      shift_type shift;
      probe_type probe;
   } cell_ctl_type;

   // Controller sequencer states.
   typedef enum logic [1:0] {
      FSM_IDLE,
      FSM_FOLD,
      FSM_DONE
   } fsm_type;

endpackage

// File: design/pol_if.sv
// Request and response channel interfaces of the positional ordered list.
interface pol_req_if;
   import pol_pkg::*;

   logic                         valid;
   logic                         ready;
   logic [REQ_TYPE_W-1:0]        req_type;
   logic signed [ITEM_W-1:0]     item_value;
   logic [POSITION_W-1:0]        position;

   modport source (output valid, output req_type, output item_value, output position,
                   input ready);
   modport sink   (input valid, input req_type, input item_value, input position,
                   output ready);
endinterface

interface pol_rsp_if;
   import pol_pkg::*;

   logic                         valid;
   logic                         ready;
   logic [STATUS_W-1:0]          status;
   logic signed [ITEM_W-1:0]     removed_value;
   logic [POSITION_W-1:0]        found_position;
   logic [POSITION_W-1:0]        length;

   modport source (output valid, output status, output removed_value,
                   output found_position, output length, input ready);
   modport sink   (input valid, input status, input removed_value,
                   input found_position, input length, output ready);
endinterface

// File: design/pol_cell.sv
// One element cell: a stored value that shifts with its neighbors, plus a probe register.
module pol_cell #(
   parameter int VALUE_WIDTH = 32,
   parameter int INDEX       = 0,
   parameter int IW          = 6,
   parameter int CW          = 7
) (
   input  logic                    clock,
   input  pol_pkg::cell_ctl_type   ctl,
   input  logic [IW-1:0]           idx,
   input  logic [CW-1:0]           count,
   input  logic [VALUE_WIDTH-1:0]  new_value,
   input  logic [VALUE_WIDTH-1:0]  left_value,
   input  logic [VALUE_WIDTH-1:0]  right_value,
   input  logic                    fold_a_hit,
   input  logic [VALUE_WIDTH-1:0]  fold_a_val,
   input  logic [IW-1:0]           fold_a_idx,
   input  logic                    fold_b_hit,
   input  logic [VALUE_WIDTH-1:0]  fold_b_val,
   input  logic [IW-1:0]           fold_b_idx,
   output logic [VALUE_WIDTH-1:0]  value,
   output logic                    probe_hit,
   output logic [VALUE_WIDTH-1:0]  probe_val,
   output logic [IW-1:0]           probe_idx
);
   import pol_pkg::*;

   localparam logic [IW-1:0] MY_IDX = IW'(INDEX);
   localparam logic [CW-1:0] MY_POS = CW'(INDEX);

   logic [VALUE_WIDTH-1:0] value_ff, value_in;
   logic                   hit_ff, hit_in;
   logic [VALUE_WIDTH-1:0] pval_ff, pval_in;
   logic [IW-1:0]          pidx_ff, pidx_in;

   // Element value: open a gap at the insert slot, or close it at the delete slot.
   always_comb begin
      value_in = value_ff;
      case (ctl.shift)
         SH_INSERT: begin
            if (MY_IDX > idx) begin
               value_in = left_value;
            end else if (MY_IDX == idx) begin
               value_in = new_value;
            end
         end
         SH_DELETE: begin
            if (MY_IDX >= idx) begin
               value_in = right_value;
            end
         end
         default: value_in = value_ff;
      endcase
   end

   // Probe: load a delete or search candidate, or fold two probes of the level below.
   always_comb begin
      hit_in  = hit_ff;
      pval_in = pval_ff;
      pidx_in = pidx_ff;
      case (ctl.probe)
         PR_LOAD_DEL: begin
            hit_in  = (MY_IDX == idx);
            pval_in = value_ff;
            pidx_in = MY_IDX;
         end
         PR_LOAD_SEARCH: begin
            hit_in  = (MY_POS < count) && (value_ff == new_value);
            pval_in = value_ff;
            pidx_in = MY_IDX;
         end
         PR_FOLD: begin
            // The lower position wins, which keeps the first match of a search.
            hit_in = fold_a_hit | fold_b_hit;
            if (fold_a_hit) begin
               pval_in = fold_a_val;
               pidx_in = fold_a_idx;
            end else begin
               pval_in = fold_b_val;
               pidx_in = fold_b_idx;
            end
         end
         default: hit_in = hit_ff;
      endcase
   end

   // Payload registers only; nothing here needs a reset.
   always_ff @(posedge clock) begin
      value_ff <= value_in;
      hit_ff   <= hit_in;
      pval_ff  <= pval_in;
      pidx_ff  <= pidx_in;
   end

   assign value     = value_ff;
   assign probe_hit = hit_ff;
   assign probe_val = pval_ff;
   assign probe_idx = pidx_ff;

endmodule

// File: design/pol_ctrl.sv
// Controller: decodes requests, keeps the element count, sequences the probe fold.
module pol_ctrl #(
   parameter int CAPACITY    = 64,
   parameter int VALUE_WIDTH = 32,
   parameter int IW          = 6,
   parameter int CW          = 7,
   parameter int LEVELS      = 6
) (
   input  logic                    clock,
   input  logic                    reset,
   pol_req_if.sink                 req_if,
   pol_rsp_if.source               rsp_if,
   output pol_pkg::cell_ctl_type   cell_ctl,
   output logic [IW-1:0]           cell_idx,
   output logic [VALUE_WIDTH-1:0]  ins_value,
   output logic [CW-1:0]           count,
   input  logic                    head_hit,
   input  logic [VALUE_WIDTH-1:0]  head_val,
   input  logic [IW-1:0]           head_idx
);
   import pol_pkg::*;

   localparam int CMPW = (CW + 1 > POSITION_W) ? CW + 1 : POSITION_W;
   localparam int FW   = $clog2(LEVELS + 1);

   fsm_type                 state_ff, state_in;
   logic [CW-1:0]           count_ff, count_in;
   logic [FW-1:0]           fold_cnt_ff, fold_cnt_in;
   logic                    search_ff, search_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0]     status_ff, status_in;
   logic [ITEM_W-1:0]       removed_ff, removed_in;
   logic [POSITION_W-1:0]   found_ff, found_in;
   logic [POSITION_W-1:0]   length_ff, length_in;

   logic                    accept;
   logic                    fold_last;
   logic [CMPW-1:0]         pos_x, cnt_x;
   logic                    full, empty;
   status_type              dec_status;
   shift_type               dec_shift;
   probe_type               dec_probe;
   logic [IW-1:0]           dec_idx;
   logic                    dec_fold;

   assign accept    = req_if.valid && req_if.ready;
   assign fold_last = (fold_cnt_ff == FW'(LEVELS - 1));
   assign pos_x     = CMPW'(req_if.position);
   assign cnt_x     = CMPW'(count_ff);
   assign full      = (cnt_x == CMPW'(CAPACITY));
   assign empty     = (count_ff == '0);
   assign ins_value = VALUE_WIDTH'(req_if.item_value);

   // Request decode with the error checks in the order the list defines them.
   always_comb begin
      dec_status = ST_OK;
      dec_shift  = SH_HOLD;
      dec_probe  = PR_HOLD;
      dec_idx    = '0;
      dec_fold   = 1'b0;
      case (op_type'(req_if.req_type))
         OP_INS_FRONT, OP_INS_BACK: begin
            if (full) begin
               dec_status = ST_FULL;
            end else begin
               dec_shift = SH_INSERT;
               dec_idx   = (op_type'(req_if.req_type) == OP_INS_FRONT) ? '0 : IW'(count_ff);
            end
         end
         OP_INS_POS: begin
            if (pos_x == '0 || pos_x > cnt_x + 1'b1) begin
               dec_status = ST_BADPOS;
            end else if (full) begin
               dec_status = ST_FULL;
            end else begin
               dec_shift = SH_INSERT;
               dec_idx   = IW'(pos_x - 1'b1);
            end
         end
         OP_DEL_FRONT, OP_DEL_BACK: begin
            if (empty) begin
               dec_status = ST_EMPTY;
            end else begin
               dec_shift = SH_DELETE;
               dec_probe = PR_LOAD_DEL;
               dec_fold  = 1'b1;
               dec_idx   = (op_type'(req_if.req_type) == OP_DEL_FRONT) ? '0 :
                           IW'(count_ff - 1'b1);
            end
         end
         OP_DEL_POS: begin
            if (empty) begin
               dec_status = ST_EMPTY;
            end else if (pos_x == '0 || pos_x > cnt_x) begin
               dec_status = ST_BADPOS;
            end else begin
               dec_shift = SH_DELETE;
               dec_probe = PR_LOAD_DEL;
               dec_fold  = 1'b1;
               dec_idx   = IW'(pos_x - 1'b1);
            end
         end
         OP_SEARCH: begin
            if (empty) begin
               dec_status = ST_EMPTY;
            end else begin
               dec_probe = PR_LOAD_SEARCH;
               dec_fold  = 1'b1;
            end
         end
         default: dec_status = ST_OK;
      endcase
   end

   // Next state of the sequencer.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         FSM_IDLE: if (accept && dec_fold) state_in = FSM_FOLD;
         FSM_FOLD: if (fold_last) state_in = FSM_DONE;
         FSM_DONE: state_in = FSM_IDLE;
         default:  state_in = FSM_IDLE;
      endcase
   end

   // Sequencer outputs: handshake, cell control and the fold counter.
   always_comb begin
      req_if.ready   = 1'b0;
      cell_ctl.shift = SH_HOLD;
      cell_ctl.probe = PR_HOLD;
      fold_cnt_in    = '0;
      case (state_ff)
         FSM_IDLE: begin
            req_if.ready = !rsp_valid_ff || rsp_if.ready;
            if (req_if.valid && (!rsp_valid_ff || rsp_if.ready)) begin
               cell_ctl.shift = dec_shift;
               cell_ctl.probe = dec_probe;
            end
         end
         FSM_FOLD: begin
            cell_ctl.probe = PR_FOLD;
            fold_cnt_in    = fold_cnt_ff + 1'b1;
         end
         default: fold_cnt_in = '0;
      endcase
   end

   assign cell_idx = dec_idx;

   // Element count and the kind of the request that is being folded.
   always_comb begin
      count_in  = count_ff;
      search_in = search_ff;
      if (accept) begin
         search_in = (dec_probe == PR_LOAD_SEARCH);
         if (dec_shift == SH_INSERT) begin
            count_in = count_ff + 1'b1;
         end else if (dec_shift == SH_DELETE) begin
            count_in = count_ff - 1'b1;
         end
      end
   end

   // Response register: immediate results at accept, folded results when done.
   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_if.ready;
      status_in    = status_ff;
      removed_in   = removed_ff;
      found_in     = found_ff;
      length_in    = length_ff;
      if (accept && !dec_fold) begin
         rsp_valid_in = 1'b1;
         status_in    = dec_status;
         removed_in   = '0;
         found_in     = '0;
         length_in    = POSITION_W'(count_in);
      end else if (state_ff == FSM_DONE) begin
         rsp_valid_in = 1'b1;
         length_in    = POSITION_W'(count_ff);
         if (search_ff) begin
            removed_in = '0;
            if (head_hit) begin
               status_in = ST_OK;
               found_in  = POSITION_W'((IW + 1)'(head_idx) + 1'b1);
            end else begin
               status_in = ST_NOTFOUND;
               found_in  = '0;
            end
         end else begin
            status_in  = ST_OK;
            removed_in = ITEM_W'(signed'(head_val));
            found_in   = '0;
         end
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= FSM_IDLE;
         count_ff     <= '0;
         fold_cnt_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         fold_cnt_ff  <= fold_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      search_ff  <= search_in;
      status_ff  <= status_in;
      removed_ff <= removed_in;
      found_ff   <= found_in;
      length_ff  <= length_in;
   end

   assign count                = count_ff;
   assign rsp_if.valid          = rsp_valid_ff;
   assign rsp_if.status         = status_ff;
   assign rsp_if.removed_value  = removed_ff;
   assign rsp_if.found_position = found_ff;
   assign rsp_if.length         = length_ff;

`ifndef SYNTHESIS
   // The list never holds more than its capacity.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      CMPW'(count_ff) <= CMPW'(CAPACITY))
      else $error("element count above capacity");

   // An accepted insert grows the list by one.
   a_insert_grows: assert property (@(posedge clock) disable iff (reset)
      (accept && dec_shift == SH_INSERT) |=> count_ff == $past(count_ff) + 1'b1)
      else $error("insert did not grow the list");

   // An accepted delete shrinks the list by one.
   a_delete_shrinks: assert property (@(posedge clock) disable iff (reset)
      (accept && dec_shift == SH_DELETE) |=> count_ff == $past(count_ff) - 1'b1)
      else $error("delete did not shrink the list");

   // The fold ends after its last level.
   a_fold_ends: assert property (@(posedge clock) disable iff (reset)
      (state_ff == FSM_FOLD && fold_last) |=> state_ff == FSM_DONE)
      else $error("fold did not finish");

   // The response register is free when a folded result is written.
   a_done_free: assert property (@(posedge clock) disable iff (reset)
      (state_ff == FSM_DONE) |-> !rsp_valid_ff)
      else $error("folded result would overwrite a pending response");
`endif

endmodule

// File: design/positional_ordered_list_top.sv
// Top level of the positional ordered list: controller and the row of element cells.
//
// Usage: requests enter on req_if (valid/ready); one response leaves on rsp_if for
// every request, in order. A request carries req_type, item_value and position; the
// response carries status, removed_value, found_position and the length after it.
// Elements live in a row of CAPACITY cells; an insert opens a gap by shifting the
// cells above the slot up by one, a delete closes it by shifting them down.
// Inserts, the unused code and requests refused with an error status give their
// response in the cycle after acceptance. Deletes and searches load a probe in
// every cell and fold it pairwise, one level a cycle, in the FOLD state; their
// response is then registered from the DONE state.
// The block works on one request at a time and takes the next one when the
// response register is empty or being emptied in the same cycle.
// Reset (synchronous, active high) empties the list at once; element values are
// not cleared. A stalled receiver holds the response in its register, and no new
// request is taken until it is accepted.
module positional_ordered_list_top #(
   parameter int CAPACITY    = pol_pkg::DEF_CAPACITY,
   parameter int VALUE_WIDTH = pol_pkg::DEF_VALUE_WIDTH
) (
   input  logic       clock,
   input  logic       reset,
   pol_req_if.sink    req_if,
   pol_rsp_if.source  rsp_if
);
   import pol_pkg::*;

   localparam int IW     = $clog2(CAPACITY);
   localparam int CW     = $clog2(CAPACITY + 1);
   localparam int LEVELS = $clog2(CAPACITY);

   cell_ctl_type            cell_ctl;
   logic [IW-1:0]           cell_idx;
   logic [VALUE_WIDTH-1:0]  ins_value;
   logic [CW-1:0]           count;

   logic [VALUE_WIDTH-1:0]  cell_value [CAPACITY];
   logic                    probe_hit  [CAPACITY];
   logic [VALUE_WIDTH-1:0]  probe_val  [CAPACITY];
   logic [IW-1:0]           probe_idx  [CAPACITY];

   pol_ctrl #(
      .CAPACITY    (CAPACITY),
      .VALUE_WIDTH (VALUE_WIDTH),
      .IW          (IW),
      .CW          (CW),
      .LEVELS      (LEVELS)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_if    (req_if),
      .rsp_if    (rsp_if),
      .cell_ctl  (cell_ctl),
      .cell_idx  (cell_idx),
      .ins_value (ins_value),
      .count     (count),
      .head_hit  (probe_hit[0]),
      .head_val  (probe_val[0]),
      .head_idx  (probe_idx[0])
   );

   // Row of cells: neighbor links for shifting, pairwise links for the probe fold.
   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic [VALUE_WIDTH-1:0] left_v, right_v;
      logic                   a_hit, b_hit;
      logic [VALUE_WIDTH-1:0] a_val, b_val;
      logic [IW-1:0]          a_idx, b_idx;

      if (i == 0) begin : g_first
         assign left_v = '0;
      end else begin : g_left
         assign left_v = cell_value[i-1];
      end

      if (i == CAPACITY - 1) begin : g_last
         assign right_v = '0;
      end else begin : g_right
         assign right_v = cell_value[i+1];
      end

      if (2 * i < CAPACITY) begin : g_fold_a
         assign a_hit = probe_hit[2*i];
         assign a_val = probe_val[2*i];
         assign a_idx = probe_idx[2*i];
      end else begin : g_no_a
         assign a_hit = 1'b0;
         assign a_val = '0;
         assign a_idx = '0;
      end

      if (2 * i + 1 < CAPACITY) begin : g_fold_b
         assign b_hit = probe_hit[2*i+1];
         assign b_val = probe_val[2*i+1];
         assign b_idx = probe_idx[2*i+1];
      end else begin : g_no_b
         assign b_hit = 1'b0;
         assign b_val = '0;
         assign b_idx = '0;
      end

      pol_cell #(
         .VALUE_WIDTH (VALUE_WIDTH),
         .INDEX       (i),
         .IW          (IW),
         .CW          (CW)
      ) u_cell (
         .clock       (clock),
         .ctl         (cell_ctl),
         .idx         (cell_idx),
         .count       (count),
         .new_value   (ins_value),
         .left_value  (left_v),
         .right_value (right_v),
         .fold_a_hit  (a_hit),
         .fold_a_val  (a_val),
         .fold_a_idx  (a_idx),
         .fold_b_hit  (b_hit),
         .fold_b_val  (b_val),
         .fold_b_idx  (b_idx),
         .value       (cell_value[i]),
         .probe_hit   (probe_hit[i]),
         .probe_val   (probe_val[i]),
         .probe_idx   (probe_idx[i])
      );
   end

endmodule

// File: dv/tb_top.sv
// Self-checking positional ordered list testbench: directed and random traffic against a queue model.
`timescale 1ns / 1ps

module tb_top;
   import pol_pkg::*;

   localparam int CAPACITY     = DEF_CAPACITY;
   localparam int IDLE_PCT     = 14;
   localparam int RANDOM_ITEMS = 400;
   localparam int PHASE_ITEMS  = 70;
   localparam int HOLD_CYCLES  = 200;
   localparam int DRAIN_CYCLES = 24;

   // The one request code that the package leaves unnamed; the block treats it as a no-op.
   localparam logic [REQ_TYPE_W-1:0] OP_UNUSED = 3'd7;

   // One predicted response.
   typedef struct packed {
      status_type               status;
      logic signed [ITEM_W-1:0] removed_value;
      logic [POSITION_W-1:0]    found_position;
      logic [POSITION_W-1:0]    length;
   } list_result_type;

   // Keeps a shadow copy of the list, predicts each response and checks it on arrival.
   class list_checker;
      logic signed [ITEM_W-1:0] cells[$];
      list_result_type          pending_results[$];
      int                       mismatch_count;
      int                       requests_noted;
      int                       responses_checked;
      int                       peak_length;
      int                       op_hits[8];
      int                       status_hits[8];

      function int length_now();
         return cells.size();
      endfunction

      function int pending();
         return pending_results.size();
      endfunction

      // Applies one accepted request to the shadow list and queues its response.
      function void note_request(logic [REQ_TYPE_W-1:0] code, logic signed [ITEM_W-1:0] value,
                                 logic [POSITION_W-1:0] pos);
         list_result_type r;
         int              n;
         int              slot;
         int              i;
         r.status         = ST_OK;
         r.removed_value  = '0;
         r.found_position = '0;
         n    = cells.size();
         slot = int'(pos);
         case (code)
            OP_INS_FRONT, OP_INS_BACK: begin
               if (n >= CAPACITY) r.status = ST_FULL;
               else if (code == OP_INS_FRONT) cells.push_front(value);
               else cells.push_back(value);
            end
            OP_INS_POS: begin
               // The position is judged before fullness.
               if (slot < 1 || slot > n + 1) r.status = ST_BADPOS;
               else if (n >= CAPACITY) r.status = ST_FULL;
               else cells.insert(slot - 1, value);
            end
            OP_DEL_FRONT, OP_DEL_BACK: begin
               if (n == 0) r.status = ST_EMPTY;
               else if (code == OP_DEL_FRONT) r.removed_value = cells.pop_front();
               else r.removed_value = cells.pop_back();
            end
            OP_DEL_POS: begin
               if (n == 0) r.status = ST_EMPTY;
               else if (slot < 1 || slot > n) r.status = ST_BADPOS;
               else begin
                  r.removed_value = cells[slot - 1];
                  cells.delete(slot - 1);
               end
            end
            OP_SEARCH: begin
               if (n == 0) r.status = ST_EMPTY;
               else begin
                  r.status = ST_NOTFOUND;
                  for (i = 0; i < n; i++) begin
                     if (cells[i] == value) begin
                        r.found_position = POSITION_W'(i + 1);
                        r.status         = ST_OK;
                        break;
                     end
                  end
               end
            end
            default: ;
         endcase
         r.length = POSITION_W'(cells.size());
         pending_results.push_back(r);
         requests_noted++;
         op_hits[code]++;
         status_hits[r.status]++;
         if (cells.size() > peak_length) peak_length = cells.size();
      endfunction

      task report_mismatch(string field, longint got, longint want);
         mismatch_count++;
         $display("[%0t] response %0d: %s is %0d, predicted %0d",
                  $time, responses_checked, field, got, want);
      endtask

      // Compares one accepted response with the oldest prediction.
      task check_response(logic [STATUS_W-1:0] status, logic signed [ITEM_W-1:0] removed,
                          logic [POSITION_W-1:0] found, logic [POSITION_W-1:0] len);
         list_result_type r;
         if (pending_results.size() == 0) begin
            report_mismatch("response count", responses_checked + 1, requests_noted);
         end else begin
            r = pending_results.pop_front();
            if (status !== r.status) report_mismatch("status", status, r.status);
            if (removed !== r.removed_value)
               report_mismatch("removed_value", removed, r.removed_value);
            if (found !== r.found_position)
               report_mismatch("found_position", found, r.found_position);
            if (len !== r.length) report_mismatch("length", len, r.length);
         end
         responses_checked++;
      endtask
   endclass

   logic clock;
   logic reset;
   bit   calm_stretch;
   bit   hold_off_request;

   list_checker sb = new();

   pol_req_if req_bus();
   pol_rsp_if rsp_bus();

   positional_ordered_list_top i_dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_bus),
      .rsp_if (rsp_bus)
   );

   // Free-running clock.
   initial clock = 1'b0;
   always #5 clock = ~clock;

   // Drives one request, idling at random first, and waits for it to be taken.
   task automatic send_request(logic [REQ_TYPE_W-1:0] code, logic signed [ITEM_W-1:0] value,
                               logic [POSITION_W-1:0] pos);
      while (!calm_stretch && $urandom_range(99) < IDLE_PCT) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid      <= 1'b1;
      req_bus.req_type   <= code;
      req_bus.item_value <= value;
      req_bus.position   <= pos;
      do @(posedge clock); while (!req_bus.ready);
      sb.note_request(code, value, pos);
   endtask

   // Values mostly come from a small pool so that searches hit and duplicates occur.
   function automatic logic signed [ITEM_W-1:0] pick_value();
      if ($urandom_range(9) < 3) return $urandom;
      case ($urandom_range(7))
         0: return 32'sh8000_0000;
         1: return 32'sh7FFF_FFFF;
         2: return 32'sd0;
         3: return -32'sd1;
         4: return 32'sd17;
         5: return -32'sd100;
         6: return 32'sd4096;
         default: return 32'sh5A5A_A5A5;
      endcase
   endfunction

   // A position outside the legal range, bounded by the largest legal one.
   function automatic logic [POSITION_W-1:0] bad_position(int legal_max);
      if ($urandom_range(1) == 0) return '0;
      return POSITION_W'($urandom_range(127, legal_max + 1));
   endfunction

   // Response side: checks accepted responses and stalls at random.
   initial begin : response_sink
      int hold_cycles;
      hold_cycles = 0;
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_bus.valid && rsp_bus.ready)
            sb.check_response(rsp_bus.status, rsp_bus.removed_value, rsp_bus.found_position,
                              rsp_bus.length);
         if (hold_off_request) begin
            hold_off_request = 1'b0;
            hold_cycles      = HOLD_CYCLES;
         end
         if (hold_cycles > 0) begin
            hold_cycles--;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= calm_stretch || ($urandom_range(99) >= IDLE_PCT);
         end
      end
   end

   // Request side: reset, directed cases, then phased random traffic.
   initial begin : request_source
      int                       k;
      int                       n;
      int                       phase;
      int                       roll;
      logic [REQ_TYPE_W-1:0]    code;
      logic [POSITION_W-1:0]    pos;

      reset              <= 1'b1;
      req_bus.valid      <= 1'b0;
      req_bus.req_type   <= OP_INS_FRONT;
      req_bus.item_value <= '0;
      req_bus.position   <= '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Every refusal on an empty list.
      send_request(OP_SEARCH, 32'sd5, 7'd0);
      send_request(OP_DEL_FRONT, 32'sd0, 7'd0);
      send_request(OP_DEL_BACK, 32'sd0, 7'd0);
      send_request(OP_DEL_POS, 32'sd0, 7'd1);
      send_request(OP_INS_POS, 32'sd9, 7'd0);
      send_request(OP_INS_POS, 32'sd9, 7'd2);
      // Build a short list with the value extremes and check positional inserts.
      send_request(OP_INS_FRONT, 32'sh7FFF_FFFF, 7'd0);
      send_request(OP_INS_BACK, 32'sh8000_0000, 7'd0);
      send_request(OP_INS_POS, 32'sd0, 7'd2);
      send_request(OP_INS_POS, -32'sd1, 7'd4);
      send_request(OP_INS_POS, 32'sd3, 7'd127);
      // Searches: a hit, a miss, then a duplicate so the first match wins.
      send_request(OP_SEARCH, -32'sd1, 7'd0);
      send_request(OP_SEARCH, 32'sd12345, 7'd0);
      send_request(OP_INS_FRONT, -32'sd1, 7'd0);
      send_request(OP_SEARCH, -32'sd1, 7'd0);
      // Positional deletes out of range on a non-empty list, then the legal deletes.
      send_request(OP_DEL_POS, 32'sd0, 7'd0);
      send_request(OP_DEL_POS, 32'sd0, 7'd6);
      send_request(OP_DEL_POS, 32'sd0, 7'd127);
      send_request(OP_DEL_POS, 32'sd0, 7'd3);
      send_request(OP_DEL_FRONT, 32'sd0, 7'd0);
      send_request(OP_DEL_BACK, 32'sd0, 7'd0);
      send_request(OP_UNUSED, 32'sh1234_5678, 7'd64);

      // Phases cycle through fill, mixed, drain and mixed traffic.
      for (k = 0; k < RANDOM_ITEMS; k++) begin
         calm_stretch = (k >= 140 && k < 220);
         if (k == 300) hold_off_request = 1'b1;
         n     = sb.length_now();
         phase = (k / PHASE_ITEMS) % 4;
         roll  = $urandom_range(99);
         if (phase == 0 && roll < 95)
            code = OP_INS_FRONT + REQ_TYPE_W'($urandom_range(2));
         else if (phase == 2 && roll < 97)
            code = OP_DEL_FRONT + REQ_TYPE_W'($urandom_range(2));
         else if (roll == 0)
            code = OP_UNUSED;
         else
            code = REQ_TYPE_W'($urandom_range(OP_SEARCH));

         pos = POSITION_W'($urandom_range(127));
         if (code == OP_INS_POS)
            pos = ($urandom_range(9) > 0) ? POSITION_W'($urandom_range(n + 1, 1))
                                          : bad_position(n + 1);
         else if (code == OP_DEL_POS && n > 0)
            pos = ($urandom_range(9) > 0) ? POSITION_W'($urandom_range(n, 1))
                                          : bad_position(n);
         send_request(code, pick_value(), pos);
      end
      calm_stretch = 1'b0;

      // Let every outstanding response arrive, then watch for strays.
      req_bus.valid <= 1'b0;
      while (sb.pending() > 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Covered %0d requests (%0d inserts, %0d deletes, %0d searches), %0d responses.",
               sb.requests_noted,
               sb.op_hits[OP_INS_FRONT] + sb.op_hits[OP_INS_BACK] + sb.op_hits[OP_INS_POS],
               sb.op_hits[OP_DEL_FRONT] + sb.op_hits[OP_DEL_BACK] + sb.op_hits[OP_DEL_POS],
               sb.op_hits[OP_SEARCH], sb.responses_checked);
      $display("Peak length %0d; full %0d, empty %0d, bad position %0d, not found %0d.",
               sb.peak_length, sb.status_hits[ST_FULL], sb.status_hits[ST_EMPTY],
               sb.status_hits[ST_BADPOS], sb.status_hits[ST_NOTFOUND]);
      if (sb.mismatch_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

   // Watchdog for a hung handshake.
   initial begin : watchdog
      #2_000_000;
      $display("Timeout with %0d responses outstanding.", sb.pending());
      $display("*** FAILED ***");
      $finish;
   end

endmodule

// File: sim.f
design/pol_pkg.sv
design/pol_if.sv
design/pol_cell.sv
design/pol_ctrl.sv
design/positional_ordered_list_top.sv
dv/tb_top.sv
